// ===== design/hmkt_pkg.sv =====
// Shared types and constants of the keyed multiset table.
`default_nettype none
package hmkt_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_ERASE  = 2'd2;

	localparam int COUNT_MAX = 127;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} hmkt_state_t;

	typedef struct packed {
		logic clear_wr;  // clearing pass: write an empty slot at the sweep index
		logic start;     // capture the item, restart sweep and tallies
		logic scan_rd;   // read the slot at the sweep index
		logic commit;    // apply insert, update total, load the result register
	} hmkt_cmd_t;

	typedef struct packed {
		logic idx_last;  // sweep index sits on the last slot
	} hmkt_stat_t;

endpackage
`default_nettype wire

// ===== design/hmkt_ctrl.sv =====
// Controller state machine: clearing pass, slot sweep, commit and result handshake.
`default_nettype none
module hmkt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hmkt_pkg::hmkt_cmd_t   cmd,
	input  wire hmkt_pkg::hmkt_stat_t stat
);
	import hmkt_pkg::*;

	hmkt_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (stat.idx_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (stat.idx_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear_wr = 1'b1;
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN:   cmd.scan_rd = 1'b1;
			ST_DRAIN:  ;
			ST_COMMIT: cmd.commit = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== design/hmkt_dpath.sv =====
// Datapath: slot memory, sweep counter, match tally, free-slot search and result register.
`default_nettype none
module hmkt_dpath #(
	parameter int CAPACITY = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hmkt_pkg::hmkt_cmd_t  cmd,
	output hmkt_pkg::hmkt_stat_t      stat,
	input  wire logic [1:0]           mode,
	input  wire logic signed [31:0]   key,
	output logic                      found,
	output logic [6:0]                match_count,
	output logic [6:0]                total_entries,
	output logic                      status
);
	import hmkt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// slot word: {valid, key}
	logic [32:0]   mem [CAPACITY];
	logic [32:0]   rdata_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] addr_s1;

	logic [AW-1:0] idx_q;
	logic [1:0]    mode_q;
	logic [31:0]   key_q;
	logic [CW-1:0] match_q;
	logic [CW-1:0] total_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;

	logic          hit;
	logic          ins_ok;
	logic          erase_wr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [32:0]   wdata;
	logic [CW-1:0] total_next;

	function automatic logic [6:0] sat7(input logic [CW-1:0] v);
		logic [31:0] ext;
		ext = 32'(v);
		return (ext > 32'(COUNT_MAX)) ? 7'(COUNT_MAX) : ext[6:0];
	endfunction

	assign stat.idx_last = (idx_q == AW'(CAPACITY - 1));

	assign hit      = rd_vld_s1 && rdata_s1[32] && (rdata_s1[31:0] == key_q);
	assign erase_wr = hit && (mode_q == MODE_ERASE);
	assign ins_ok   = (mode_q == MODE_INSERT) && free_found_q
	                  && (total_q < CW'(CAPACITY));

	// one write port: clearing pass, erase write-back, insert at commit
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		priority if (cmd.clear_wr) begin
			we = 1'b1;
		end else if (erase_wr) begin
			we    = 1'b1;
			waddr = addr_s1;
		end else if (cmd.commit && ins_ok) begin
			we    = 1'b1;
			waddr = free_idx_q;
			wdata = {1'b1, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (cmd.scan_rd)
			rdata_s1 <= mem[idx_q];
		addr_s1 <= idx_q;
	end

	always_comb begin
		total_next = total_q;
		if (ins_ok)
			total_next = total_q + CW'(1);
		else if (mode_q == MODE_ERASE)
			total_next = total_q - match_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			total_q      <= '0;
			match_q      <= '0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.start)
				idx_q <= '0;
			else if (cmd.clear_wr || cmd.scan_rd)
				idx_q <= stat.idx_last ? '0 : idx_q + AW'(1);

			if (cmd.start) begin
				match_q      <= '0;
				free_found_q <= 1'b0;
			end else begin
				if (hit)
					match_q <= match_q + CW'(1);
				if (rd_vld_s1 && !rdata_s1[32] && !free_found_q)
					free_found_q <= 1'b1;
			end

			if (cmd.commit)
				total_q <= total_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= mode;
			key_q  <= key;
		end
		if (rd_vld_s1 && !rdata_s1[32] && !free_found_q)
			free_idx_q <= addr_s1;
		if (cmd.commit) begin
			found         <= (match_q != '0);
			match_count   <= sat7(match_q);
			total_entries <= sat7(total_next);
			status        <= (mode_q == MODE_INSERT) && !ins_ok;
		end
	end

endmodule
`default_nettype wire

// ===== design/hash_multiset_key_table.sv =====
// Top level of the keyed multiset table: controller plus datapath.
// One item at a time: a request is taken only in idle, after the previous one
//   has been committed; the sweep reads one slot per cycle through the single
//   read port of the slot memory.
// Reset: arst_n clears control state, then a clearing pass empties every
//   slot; no input is taken until it ends.
`default_nettype none
module hash_multiset_key_table #(
	parameter int CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic signed [31:0] key,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    found,
	output logic [6:0]              match_count,
	output logic [6:0]              total_entries,
	output logic                    status
);
	import hmkt_pkg::*;

	hmkt_cmd_t  cmd;
	hmkt_stat_t stat;

	// Sequencer: owns the handshakes; a finished result sits in the output
	// register while the next request may already be taken.
	hmkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Slot store and sweep: each slot is compared with the key in turn, the
	// match tally and the lowest free slot are gathered, erase clears each
	// matching slot as it passes, insert writes the free slot at commit.
	hmkt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.key           (key),
		.found         (found),
		.match_count   (match_count),
		.total_entries (total_entries),
		.status        (status)
	);

endmodule
`default_nettype wire

// ===== design/hmkt_checker.sv =====
// Port-level checks of the keyed multiset table, bound to the top level.
`default_nettype none
module hmkt_checker #(
	parameter int CAPACITY = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic [6:0]  match_count,
	input wire logic [6:0]  total_entries,
	input wire logic        status
);
	localparam int CapSat = (CAPACITY > 127) ? 127 : CAPACITY;

	// a held result keeps its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_count)
		&& $stable(total_entries) && $stable(found) && $stable(status))
		else $error("result changed while stalled");

	// one item at a time: busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// found agrees with the match count
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (match_count != 7'd0)))
		else $error("found and match_count disagree");

	// rejected insert only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> total_entries == 7'(CapSat))
		else $error("insert rejected while not full");

endmodule

bind hash_multiset_key_table hmkt_checker #(.CAPACITY(CAPACITY)) u_hmkt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.match_count   (match_count),
	.total_entries (total_entries),
	.status        (status)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the keyed multiset table: directed, full-store and random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hmkt_pkg::*;

	localparam int CAPACITY = 64;
	// mode 3 has no name in the package; the block treats it as a look up
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 850;
	// longest quiet spell: receiver hold-off + sender gap + one item
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 2 * (CAPACITY + 3);
	localparam int POOL_DEPTH = 8;

	typedef struct {
		logic       found;
		logic [6:0] match_count;
		logic [6:0] total_entries;
		logic       status;
	} table_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic signed [31:0] key;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [6:0]         match_count;
	logic [6:0]         total_entries;
	logic               status;

	hash_multiset_key_table #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.key          (key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_count  (match_count),
		.total_entries(total_entries),
		.status       (status)
	);

	// Mirror of the store: which slots are live, what they hold, how many there are.
	bit            mirror_used [CAPACITY];
	logic [31:0]   mirror_key  [CAPACITY];
	int            mirror_total;
	table_result_t pending_results[$];

	logic [31:0]   key_pool[POOL_DEPTH];
	int            pool_size;

	int error_count;
	int items_sent;
	int burst_left;
	bit no_idle;    // when set, neither side idles
	int rx_hold;    // cycles the receiver must still hold off

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [6:0] clip_count(input int n);
		return (n > COUNT_MAX) ? 7'(COUNT_MAX) : 7'(n);
	endfunction

	// Applies one operation to the mirror and returns the result it must produce.
	// Every live slot is compared at once; an insert takes the lowest free slot.
	function automatic table_result_t multiset_apply(input logic [1:0] op,
		input logic [31:0] k);
		table_result_t r;
		int hits;
		int free_idx;
		hits = 0;
		free_idx = -1;
		for (int i = 0; i < CAPACITY; i++) begin
			if (mirror_used[i]) begin
				if (mirror_key[i] == k)
					hits++;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		r.status = 1'b0;
		if (op == MODE_INSERT) begin
			// full store: nothing stored, reported like a look up, flagged
			if (free_idx < 0 || mirror_total >= CAPACITY) begin
				r.status = 1'b1;
			end else begin
				mirror_used[free_idx] = 1'b1;
				mirror_key[free_idx] = k;
				mirror_total++;
			end
		end else if (op == MODE_ERASE) begin
			for (int i = 0; i < CAPACITY; i++)
				if (mirror_used[i] && mirror_key[i] == k)
					mirror_used[i] = 1'b0;
			mirror_total -= hits;
		end
		// look up and the spare mode change nothing
		r.found = (hits != 0);
		r.match_count = clip_count(hits);
		r.total_entries = clip_count(mirror_total);
		return r;
	endfunction

	task automatic note_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Offers one item and waits for its transfer. The sender works in bursts:
	// before each burst it may leave valid low for a random gap.
	task automatic send_item(input logic [1:0] op, input logic [31:0] k);
		int gap;
		if (!no_idle && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 4);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 6);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= op;
		key <= k;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		pending_results.insert(pending_results.size(), multiset_apply(op, k));
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Drops valid and waits until every outstanding result has come back.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic refresh_pool(input int depth);
		pool_size = depth;
		for (int i = 0; i < POOL_DEPTH; i++) begin
			case ($urandom_range(0, 7))
				0:       key_pool[i] = 32'h8000_0000;
				1:       key_pool[i] = 32'h7fff_ffff;
				2:       key_pool[i] = 32'hffff_ffff;
				default: key_pool[i] = $urandom;
			endcase
		end
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return MODE_INSERT;
		if (r < 70)
			return MODE_LOOKUP;
		if (r < 90)
			return MODE_ERASE;
		return MODE_SPARE;
	endfunction

	// Extreme keys, duplicates, every mode, erase of an absent key.
	task automatic test_directed();
		send_item(MODE_INSERT, 32'h8000_0000);
		send_item(MODE_INSERT, 32'h7fff_ffff);
		send_item(MODE_INSERT, 32'h0000_0000);
		send_item(MODE_INSERT, 32'hffff_ffff);
		send_item(MODE_INSERT, 32'h7fff_ffff);    // duplicate
		send_item(MODE_LOOKUP, 32'h7fff_ffff);    // two copies
		send_item(MODE_LOOKUP, 32'h8000_0000);
		send_item(MODE_LOOKUP, 32'h1234_5678);    // absent
		send_item(MODE_SPARE,  32'h0000_0000);    // spare mode reads like a look up
		send_item(MODE_SPARE,  32'h5555_aaaa);
		send_item(MODE_ERASE,  32'h7fff_ffff);    // removes both copies
		send_item(MODE_ERASE,  32'h7fff_ffff);    // nothing left to remove
		send_item(MODE_LOOKUP, 32'h7fff_ffff);
		send_item(MODE_ERASE,  32'hffff_ffff);
		send_item(MODE_INSERT, 32'hffff_ffff);    // reuses a freed slot, the lowest one
		send_item(MODE_LOOKUP, 32'hffff_ffff);
		send_item(MODE_ERASE,  32'haaaa_5555);
		wait_results_drained();
	endtask

	// Fill the store from a small pool, knock on it while full, then empty it.
	task automatic test_full_store(input int depth);
		int victim;
		refresh_pool(depth);
		while (mirror_total < CAPACITY)
			send_item(MODE_INSERT, key_pool[$urandom_range(0, pool_size - 1)]);
		send_item(MODE_INSERT, key_pool[0]);      // rejected, key present
		send_item(MODE_INSERT, $urandom);          // rejected, key most likely absent
		send_item(MODE_LOOKUP, key_pool[0]);
		send_item(MODE_SPARE, pick_key());
		send_item(MODE_INSERT, pick_key());        // still rejected
		while (mirror_total > 0) begin
			victim = 0;
			while (!mirror_used[victim])
				victim++;
			send_item(MODE_ERASE, mirror_key[victim]);
		end
		send_item(MODE_LOOKUP, key_pool[0]);      // store empty again
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the block holds its result and stops taking input.
	task automatic test_result_backpressure();
		wait_results_drained();
		refresh_pool(4);
		no_idle = 1'b1;
		rx_hold = 400;
		repeat (6)
			send_item(pick_mode(), pick_key());
		no_idle = 1'b0;
		wait_results_drained();
	endtask

	// Random segments: mostly pool-keyed mixes, sometimes a full-store cycle,
	// sometimes a pause until every result is back.
	task automatic test_random_mix();
		int seg;
		int len;
		while (items_sent < RANDOM_ITEMS) begin
			seg = $urandom_range(0, 11);
			no_idle = ($urandom_range(0, 4) == 0);
			if (seg == 0) begin
				test_full_store($urandom_range(1, POOL_DEPTH));
			end else if (seg == 1) begin
				wait_results_drained();
			end else begin
				refresh_pool($urandom_range(1, POOL_DEPTH));
				len = $urandom_range(10, 40);
				repeat (len)
					send_item(pick_mode(), pick_key());
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver: own stall pattern of high and low runs, a forced hold-off
	// when asked, always ready in no-idle stretches.
	initial begin : receiver
		bit level;
		int run;
		level = 1'b0;
		run = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				if (run == 0) begin
					level = ~level;
					run = level ? $urandom_range(1, 40) : $urandom_range(1, 30);
				end
				out_ready <= level;
				run--;
			end
		end
	end

	// Each result transfer is checked against the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				note_error("result transfer with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found)
					note_error($sformatf("found %b, want %b", found, want.found));
				if (match_count !== want.match_count)
					note_error($sformatf("match_count %0d, want %0d",
						match_count, want.match_count));
				if (total_entries !== want.total_entries)
					note_error($sformatf("total_entries %0d, want %0d",
						total_entries, want.total_entries));
				if (status !== want.status)
					note_error($sformatf("status %b, want %b", status, want.status));
			end
		end
	end

	// Ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("[hash_multiset_key_table] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		key = '0;
		error_count = 0;
		items_sent = 0;
		burst_left = 0;
		no_idle = 1'b0;
		rx_hold = 0;
		mirror_total = 0;
		pool_size = 1;
		for (int i = 0; i < CAPACITY; i++) begin
			mirror_used[i] = 1'b0;
			mirror_key[i] = '0;
		end
		for (int i = 0; i < POOL_DEPTH; i++)
			key_pool[i] = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset is covered by waiting on in_ready

		test_directed();
		test_full_store(1);    // one key in every slot: largest match count
		test_result_backpressure();
		test_random_mix();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[hash_multiset_key_table] OK");
		else
			$display("[hash_multiset_key_table] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hmkt_pkg.sv
design/hmkt_ctrl.sv
design/hmkt_dpath.sv
design/hash_multiset_key_table.sv
design/hmkt_checker.sv
tb/testbench.sv
